/* src/edid_pkg.sv */
// Shared types, constants and helpers for the EDID base-block parser.
// Used by edid_desc_decode and edid_block_parser; no other dependencies.
`timescale 1ns / 1ps

package edid_pkg;

    localparam int DESC_LEN = 18;

    // Byte positions and offsets inside the base block.
    localparam logic [6:0] DESC_FIRST    = 7'd54;
    localparam logic [6:0] POS_VENDOR_HI = 7'd8;
    localparam logic [6:0] POS_VENDOR_LO = 7'd9;
    localparam int         NAME_FIRST    = 5;

    // Descriptor tags and byte values.
    localparam logic [7:0] TAG_NAME  = 8'hfc;
    localparam logic [7:0] TAG_RANGE = 8'hfd;
    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] HDR_FILL  = 8'hff;
    localparam logic [7:0] HDR_EDGE  = 8'h00;

    // Record kinds.
    localparam logic [2:0] KIND_ID_OK  = 3'd0;
    localparam logic [2:0] KIND_ID_BAD = 3'd1;
    localparam logic [2:0] KIND_TIMING = 3'd2;
    localparam logic [2:0] KIND_LIMITS = 3'd3;
    localparam logic [2:0] KIND_NAME   = 3'd4;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] pixel_clock;
        logic [11:0] h_active;
        logic [11:0] h_blank;
        logic [11:0] v_active;
        logic [11:0] v_blank;
        logic [9:0]  h_sync_offset;
        logic [9:0]  h_sync_width;
        logic [5:0]  v_sync_offset;
        logic [5:0]  v_sync_width;
        logic [3:0]  sync_flags;
        logic [14:0] text_code;
    } rec_t;

    // Range limits carry an optional offset of 255 selected by a flag bit.
    function automatic logic [11:0] plus255(input logic [7:0] v, input logic f);
        return {4'b0000, v} + (f ? 12'd255 : 12'd0);
    endfunction

endpackage

/* src/edid_desc_decode.sv */
// Decodes a completed 18-byte descriptor into a timing or range-limit record.
// Depends on edid_pkg for the record type, tags and helpers.
`timescale 1ns / 1ps

module edid_desc_decode import edid_pkg::*; #(
    parameter int DESCRIPTOR_LEN = DESC_LEN
) (
    input  logic [7:0] desc [DESCRIPTOR_LEN-1],
    input  logic [7:0] last_byte,
    output logic       is_timing,
    output logic       rec_hit,
    output rec_t       rec
);

    logic [11:0] max_clock;

    // A detailed timing has a non-zero pixel clock in either byte.
    assign is_timing = (desc[0] != 8'h00) || (desc[1] != 8'h00);

    // Maximum clock times ten, as 8x + 2x.
    assign max_clock = 12'({1'b0, desc[9], 3'b000}) + 12'({3'b000, desc[9], 1'b0});

    always_comb begin
        rec     = '0;
        rec_hit = 1'b0;
        if (is_timing) begin
            rec_hit           = 1'b1;
            rec.record_kind   = KIND_TIMING;
            rec.pixel_clock   = {desc[1], desc[0]};
            rec.h_active      = {desc[4][7:4], desc[2]};
            rec.h_blank       = {desc[4][3:0], desc[3]};
            rec.v_active      = {desc[7][7:4], desc[5]};
            rec.v_blank       = {desc[7][3:0], desc[6]};
            rec.h_sync_offset = {desc[11][7:6], desc[8]};
            rec.h_sync_width  = {desc[11][5:4], desc[9]};
            rec.v_sync_offset = {desc[11][3:2], desc[10][7:4]};
            rec.v_sync_width  = {desc[11][1:0], desc[10][3:0]};
            rec.sync_flags[0] = last_byte[4] & last_byte[1];
            rec.sync_flags[1] = last_byte[4] & last_byte[2];
            rec.sync_flags[2] = last_byte[7];
            rec.sync_flags[3] = last_byte[7] | (last_byte[4] & last_byte[3]);
        end else if (desc[3] == TAG_RANGE) begin
            rec_hit         = 1'b1;
            rec.record_kind = KIND_LIMITS;
            rec.pixel_clock = {4'b0000, max_clock};
            rec.h_active    = plus255(desc[7], desc[4][2]);
            rec.h_blank     = plus255(desc[8], desc[4][3]);
            rec.v_active    = plus255(desc[5], desc[4][0]);
            rec.v_blank     = plus255(desc[6], desc[4][1]);
        end
    end

endmodule

/* src/edid_block_parser.sv */
// EDID base-block parser top level: byte tracking, header check, descriptor store.
// Depends on edid_pkg and edid_desc_decode.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------
//  s_       | in        | s_valid / s_ready   | s_edid_byte, s_block_start
//  m_       | out       | m_valid / m_ready   | m_record_kind .. m_text_code
//
// One byte a cycle is sustained while the output is not stalled: a request lands in
// an input register, is decoded there and, if it makes a record, moves to the output
// register. Reset (synchronous, aresetn low) clears position, offset, vendor byte and
// both stages and sets the header flag; the descriptor store needs no clearing since
// each byte is written before use.
// A stalled output holds the input stage; s_ready falls only while both are full.
`timescale 1ns / 1ps

module edid_block_parser import edid_pkg::*; #(
    parameter int DESCRIPTOR_LEN = DESC_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_edid_byte,
    input  logic        s_block_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_record_kind,
    output logic [15:0] m_pixel_clock,
    output logic [11:0] m_h_active,
    output logic [11:0] m_h_blank,
    output logic [11:0] m_v_active,
    output logic [11:0] m_v_blank,
    output logic [9:0]  m_h_sync_offset,
    output logic [9:0]  m_h_sync_width,
    output logic [5:0]  m_v_sync_offset,
    output logic [5:0]  m_v_sync_width,
    output logic [3:0]  m_sync_flags,
    output logic [14:0] m_text_code
);

    localparam int OFF_W = $clog2(DESCRIPTOR_LEN);
    localparam logic [6:0] DESC_END = 7'(int'(DESC_FIRST) + 4 * DESCRIPTOR_LEN);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(DESCRIPTOR_LEN - 1);

    // Input stage.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Parser state.
    logic [6:0]       pos_reg, pos_next;
    logic             header_good_reg, header_good_next;
    logic [7:0]       vendor_hi_reg, vendor_hi_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0]       desc_reg [DESCRIPTOR_LEN-1];

    // Output stage.
    logic out_valid_reg, out_valid_next;
    rec_t out_rec_reg;

    logic [6:0] pos;
    logic       out_free;
    logic       advance;
    logic       in_desc;
    logic       is_timing;
    logic       dec_hit;
    rec_t       dec_rec;
    rec_t       rec;
    logic       hit;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign pos     = in_start_reg ? 7'd0 : pos_reg;
    assign in_desc = (pos >= DESC_FIRST) && (pos < DESC_END);

    edid_desc_decode #(
        .DESCRIPTOR_LEN(DESCRIPTOR_LEN)
    ) u_decode (
        .desc      (desc_reg),
        .last_byte (in_byte_reg),
        .is_timing (is_timing),
        .rec_hit   (dec_hit),
        .rec       (dec_rec)
    );

    always_comb begin
        header_good_next = header_good_reg;
        vendor_hi_next   = vendor_hi_reg;
        rec              = '0;
        hit              = 1'b0;
        case (pos) inside
            7'd0: begin
                header_good_next = (in_byte_reg == HDR_EDGE);
            end
            [7'd1:7'd6]: begin
                if (in_byte_reg != HDR_FILL) begin
                    header_good_next = 1'b0;
                end
            end
            7'd7: begin
                if (in_byte_reg != HDR_EDGE) begin
                    header_good_next = 1'b0;
                end
            end
            POS_VENDOR_HI: begin
                vendor_hi_next = in_byte_reg;
            end
            POS_VENDOR_LO: begin
                hit             = 1'b1;
                rec.record_kind = header_good_reg ? KIND_ID_OK : KIND_ID_BAD;
                rec.text_code   = {vendor_hi_reg[6:0], in_byte_reg};
            end
            default: begin
                if (in_desc) begin
                    // Model-name characters stream out as they arrive.
                    if (!is_timing && off_reg >= OFF_W'(NAME_FIRST)
                            && desc_reg[3] == TAG_NAME) begin
                        hit             = 1'b1;
                        rec.record_kind = KIND_NAME;
                        rec.text_code   = (in_byte_reg == CHAR_LF) ? 15'd0
                                                                   : {7'd0, in_byte_reg};
                    end
                    if (off_reg == OFF_LAST && dec_hit) begin
                        hit = 1'b1;
                        rec = dec_rec;
                    end
                end
            end
        endcase
    end

    assign pos_next = pos + 7'd1;
    assign off_next = (pos == DESC_FIRST - 7'd1 || off_reg == OFF_LAST) ? '0
                                                                         : off_reg + OFF_W'(1);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && hit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pos_reg         <= 7'd0;
            header_good_reg <= 1'b1;
            vendor_hi_reg   <= 8'd0;
            off_reg         <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pos_reg         <= pos_next;
                header_good_reg <= header_good_next;
                vendor_hi_reg   <= vendor_hi_next;
                off_reg         <= off_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_edid_byte;
            in_start_reg <= s_block_start;
        end
        if (advance && hit) begin
            out_rec_reg <= rec;
        end
        // The last descriptor byte is consumed directly and never stored.
        if (advance && in_desc && off_reg != OFF_LAST) begin
            desc_reg[off_reg] <= in_byte_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_record_kind   = out_rec_reg.record_kind;
    assign m_pixel_clock   = out_rec_reg.pixel_clock;
    assign m_h_active      = out_rec_reg.h_active;
    assign m_h_blank       = out_rec_reg.h_blank;
    assign m_v_active      = out_rec_reg.v_active;
    assign m_v_blank       = out_rec_reg.v_blank;
    assign m_h_sync_offset = out_rec_reg.h_sync_offset;
    assign m_h_sync_width  = out_rec_reg.h_sync_width;
    assign m_v_sync_offset = out_rec_reg.v_sync_offset;
    assign m_v_sync_width  = out_rec_reg.v_sync_width;
    assign m_sync_flags    = out_rec_reg.sync_flags;
    assign m_text_code     = out_rec_reg.text_code;

    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg <= OFF_LAST)
        else $error("descriptor offset out of range");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_record_kind <= KIND_NAME)
        else $error("unknown record kind");

    a_no_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_record_kind == KIND_TIMING || m_record_kind == KIND_LIMITS)
        |-> m_text_code == 15'd0)
        else $error("text code set on a timing or limits record");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && hit |=> m_valid)
        else $error("decoded record was not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !advance)
        else $error("input stage advanced into a stalled output");

endmodule
